// ===== rtl/core/cch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cch_pkg
// Shared types, constants and channel decoding for the channel continuity
// hysteresis detector.
// ----------------------------------------------------------------------------
package cch_pkg;

    localparam int NUM_BOARDS         = 4;
    localparam int CHANNELS_PER_BOARD = 8;
    localparam int ADC_WIDTH          = 12;

    localparam int NUM_SAMPLES    = 8;
    localparam int NUM_MAPS       = 4;
    localparam int TOTAL_CHANNELS = NUM_BOARDS * CHANNELS_PER_BOARD;

    // Field widths of the interface.
    localparam int CH_W      = 5;
    localparam int SAMPLE_W  = 12;
    localparam int THR_W     = 12;
    localparam int MAP_W     = 24;
    localparam int MASK_W    = 8;
    localparam int POS_W     = 3;
    localparam int LOCAL_W   = 3;
    localparam int MAP_SEL_W = 2;

    // Only the low ADC_WIDTH bits of a sample take part, at most the field.
    localparam int SAMPLE_BITS = (ADC_WIDTH < SAMPLE_W) ? ADC_WIDTH : SAMPLE_W;
    localparam int SUM_W       = SAMPLE_BITS + 3;

    localparam int CH_IDX_W = (TOTAL_CHANNELS > 1) ? $clog2(TOTAL_CHANNELS) : 1;
    localparam int CH_EXT_W = (CH_IDX_W > CH_W) ? CH_IDX_W : CH_W;
    localparam int BOARD_W  = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 32;
    localparam int IN_W      = CH_W + NUM_SAMPLES * SAMPLE_W;
    localparam int OUT_W     = CH_W + 3 + THR_W + MASK_W;

    // Configuration port.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE    = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ON_THR    = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFF_THR   = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLAMP_THR = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LED_MAP0  = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_LED_MAP1  = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_LED_MAP2  = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_LED_MAP3  = 4'd7;

    localparam logic [THR_W-1:0] ON_THR_RESET    = 12'd2048;
    localparam logic [THR_W-1:0] OFF_THR_RESET   = 12'd1024;
    localparam logic [THR_W-1:0] CLAMP_THR_RESET = 12'd4095;
    localparam logic [MAP_W-1:0] LED_MAP_RESET   = 24'hFAC688;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic                               enable;
        logic [THR_W-1:0]                   on_thr;
        logic [THR_W-1:0]                   off_thr;
        logic [THR_W-1:0]                   clamp_thr;
        logic [NUM_MAPS-1:0][MAP_W-1:0]     led_map;
    } cfg_t;

    // Packed so that the channel sits in the lowest bits, then sample 0 up.
    typedef struct packed {
        sample_t [NUM_SAMPLES-1:0] samples;
        logic [CH_W-1:0]           channel;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] board_led_mask;
        logic [THR_W-1:0]  average;
        logic              clamped;
        logic              changed;
        logic              is_connected;
        logic [CH_W-1:0]   out_channel;
    } out_item_t;

    typedef struct packed {
        logic [THR_W-1:0]  average;
        logic              clamped;
        logic              now;
        logic              changed;
        logic [MASK_W-1:0] new_mask;
    } decision_t;

    // Board of a global channel: a row of independent compares.
    function automatic logic [BOARD_W-1:0] board_of(input logic [CH_EXT_W-1:0] ch);
        logic [BOARD_W-1:0] b;
        b = '0;
        for (int i = 1; i < NUM_BOARDS; i++) begin
            if (int'(ch) >= i * CHANNELS_PER_BOARD) begin
                b = BOARD_W'(i);
            end
        end
        return b;
    endfunction

endpackage

// ===== rtl/core/cch_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cch_cfg_regs
// Configuration register file: enable, the three thresholds and the four
// board LED maps, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module cch_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cch_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cch_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output cch_pkg::cfg_t                  cfg
);

    cch_pkg::cfg_t cfg_reg;
    cch_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                cch_pkg::CFG_ENABLE:    cfg_next.enable    = cfg_wdata[0];
                cch_pkg::CFG_ON_THR:    cfg_next.on_thr    = cfg_wdata[cch_pkg::THR_W-1:0];
                cch_pkg::CFG_OFF_THR:   cfg_next.off_thr   = cfg_wdata[cch_pkg::THR_W-1:0];
                cch_pkg::CFG_CLAMP_THR: cfg_next.clamp_thr = cfg_wdata[cch_pkg::THR_W-1:0];
                cch_pkg::CFG_LED_MAP0:  cfg_next.led_map[0] = cfg_wdata[cch_pkg::MAP_W-1:0];
                cch_pkg::CFG_LED_MAP1:  cfg_next.led_map[1] = cfg_wdata[cch_pkg::MAP_W-1:0];
                cch_pkg::CFG_LED_MAP2:  cfg_next.led_map[2] = cfg_wdata[cch_pkg::MAP_W-1:0];
                cch_pkg::CFG_LED_MAP3:  cfg_next.led_map[3] = cfg_wdata[cch_pkg::MAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable    <= 1'b1;
            cfg_reg.on_thr    <= cch_pkg::ON_THR_RESET;
            cfg_reg.off_thr   <= cch_pkg::OFF_THR_RESET;
            cfg_reg.clamp_thr <= cch_pkg::CLAMP_THR_RESET;
            for (int i = 0; i < cch_pkg::NUM_MAPS; i++) begin
                cfg_reg.led_map[i] <= cch_pkg::LED_MAP_RESET;
            end
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/cch_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cch_decide
// Averages the eight samples of one channel and applies the clamp override
// and the hysteresis thresholds, then works out the board's new LED mask.
// ----------------------------------------------------------------------------
module cch_decide (
    input  cch_pkg::sample_t [cch_pkg::NUM_SAMPLES-1:0] samples,
    input  logic                                        prev_flag,
    input  logic [cch_pkg::MASK_W-1:0]                  prev_mask,
    input  logic [cch_pkg::MAP_W-1:0]                   led_map,
    input  logic [cch_pkg::LOCAL_W-1:0]                 local_ch,
    input  cch_pkg::cfg_t                               cfg,
    output cch_pkg::decision_t                          dec
);

    logic [cch_pkg::SUM_W-1:0]  sum;
    logic [cch_pkg::THR_W-1:0]  avg;
    logic [cch_pkg::POS_W-1:0]  bit_pos;
    logic [cch_pkg::MASK_W-1:0] bit_sel;
    logic                       now;

    always_comb begin
        sum = '0;
        for (int i = 0; i < cch_pkg::NUM_SAMPLES; i++) begin
            sum = sum + cch_pkg::SUM_W'(samples[i][cch_pkg::SAMPLE_BITS-1:0]);
        end
    end

    // Truncating divide by eight.
    assign avg = cch_pkg::THR_W'(sum >> 3);

    always_comb begin
        if (avg >= cfg.clamp_thr) begin
            now = 1'b0;
        end else if (avg > cfg.on_thr) begin
            now = 1'b1;
        end else if (avg < cfg.off_thr) begin
            now = 1'b0;
        end else begin
            now = prev_flag;
        end
    end

    assign bit_pos = led_map[cch_pkg::POS_W * local_ch +: cch_pkg::POS_W];
    assign bit_sel = cch_pkg::MASK_W'(1) << bit_pos;

    always_comb begin
        dec.average  = avg;
        dec.clamped  = (avg >= cfg.clamp_thr);
        dec.now      = now;
        dec.changed  = (now != prev_flag);
        dec.new_mask = prev_mask;
        if (now != prev_flag) begin
            dec.new_mask = now ? (prev_mask | bit_sel) : (prev_mask & ~bit_sel);
        end
    end

endmodule

// ===== rtl/core/channel_continuity_hysteresis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_continuity_hysteresis
// Multichannel continuity detector with clamp override, hysteresis and
// per-board LED masks.
// ----------------------------------------------------------------------------
// The block takes one channel measurement per clock cycle unless the result
// register is held by back-pressure on m_tready. Each item passes through the
// input register, then the averaging and threshold logic, into the result
// register. The channel link flags and board LED masks are flip-flops
// updated as an item moves into the result register, so consecutive items
// on the same channel see each other's state without any stall. Items that
// arrive while sensing is disabled, or that name a channel beyond the last
// board, are consumed and give no result. Configuration is written through
// the cfg_ port, always ready, and must only be changed while the block is
// idle.
module channel_continuity_hysteresis (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input: channel, sample_0 .. sample_7 (lowest bit up), zero padded.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cch_pkg::S_TDATA_W-1:0]  s_tdata,
    // Result: out_channel, is_connected, changed, clamped, average,
    // board_led_mask (lowest bit up), zero padded.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cch_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cch_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cch_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    cch_pkg::cfg_t      cfg;
    cch_pkg::decision_t dec;

    logic               in_valid_reg;
    logic               in_valid_next;
    cch_pkg::in_item_t  in_item_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    cch_pkg::out_item_t out_item_reg;
    cch_pkg::out_item_t out_item_next;

    logic [cch_pkg::TOTAL_CHANNELS-1:0]             link_flags_reg;
    logic [cch_pkg::TOTAL_CHANNELS-1:0]             link_flags_next;
    logic [cch_pkg::NUM_BOARDS-1:0][cch_pkg::MASK_W-1:0] led_mask_reg;
    logic [cch_pkg::NUM_BOARDS-1:0][cch_pkg::MASK_W-1:0] led_mask_next;

    logic [cch_pkg::CH_EXT_W-1:0]  ch_ext;
    logic [cch_pkg::CH_IDX_W-1:0]  ch_idx;
    logic [cch_pkg::BOARD_W-1:0]   board;
    logic [cch_pkg::LOCAL_W-1:0]   local_ch;
    logic [cch_pkg::MAP_SEL_W-1:0] map_sel;
    logic                          ch_ok;
    logic                          item_ok;
    logic                          out_free;
    logic                          advance;

    cch_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Channel decoding.
    assign ch_ext   = cch_pkg::CH_EXT_W'(in_item_reg.channel);
    assign ch_idx   = ch_ext[cch_pkg::CH_IDX_W-1:0];
    assign ch_ok    = (int'(ch_ext) < cch_pkg::TOTAL_CHANNELS);
    assign board    = cch_pkg::board_of(ch_ext);
    assign local_ch = cch_pkg::LOCAL_W'(int'(ch_ext) - int'(board) * cch_pkg::CHANNELS_PER_BOARD);
    assign map_sel  = cch_pkg::MAP_SEL_W'(board);
    assign item_ok  = cfg.enable && ch_ok;

    cch_decide u_decide (
        .samples   (in_item_reg.samples),
        .prev_flag (link_flags_reg[ch_idx]),
        .prev_mask (led_mask_reg[board]),
        .led_map   (cfg.led_map[map_sel]),
        .local_ch  (local_ch),
        .cfg       (cfg),
        .dec       (dec)
    );

    // The result register frees up when empty or when its transaction goes.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = in_valid_reg && item_ok;
        end
        out_item_next.out_channel    = in_item_reg.channel;
        out_item_next.is_connected   = dec.now;
        out_item_next.changed        = dec.changed;
        out_item_next.clamped        = dec.clamped;
        out_item_next.average        = dec.average;
        out_item_next.board_led_mask = dec.new_mask;
    end

    always_comb begin
        link_flags_next = link_flags_reg;
        led_mask_next   = led_mask_reg;
        if (advance && item_ok) begin
            link_flags_next[ch_idx] = dec.now;
            led_mask_next[board]    = dec.new_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            link_flags_reg <= '0;
            led_mask_reg   <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            link_flags_reg <= link_flags_next;
            led_mask_reg   <= led_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_tdata[cch_pkg::IN_W-1:0];
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cch_pkg::M_TDATA_W'(out_item_reg);

    // A clamped measurement always leaves the channel open.
    a_clamp_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_item_reg.clamped) |-> !out_item_reg.is_connected)
        else $error("clamped result reports a connected channel");

    // A dropped item empties the result register rather than leaving a stale one.
    a_drop_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !item_ok) |=> !out_valid_reg)
        else $error("dropped item produced a result");

    // A reported change really flips the stored link flag.
    a_change_flips: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_ok && dec.changed) |=>
            (link_flags_reg[$past(ch_idx)] != $past(link_flags_reg[ch_idx])))
        else $error("change flag set without link flag update");

    // The result register shows the state that was just stored for the channel.
    a_state_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_ok) |=>
            (out_item_reg.is_connected == link_flags_reg[$past(ch_idx)]))
        else $error("result state differs from stored link flag");

endmodule

// ===== tb/sv/tb_channel_continuity_hysteresis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_continuity_hysteresis
// Self-checking testbench for the channel continuity hysteresis detector.
// ----------------------------------------------------------------------------
// A queue of channel measurements feeds a clocked driver. Each accepted input
// transaction passes through a local model of the averaging, clamp,
// hysteresis and LED mask logic, and the link reports that it predicts are
// matched in order against the result transactions. The run covers reset
// settings, crossed and extreme thresholds, disabled sensing and random LED
// maps, first with directed measurements and then random ones under several
// patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_channel_continuity_hysteresis;
    import cch_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // channel, sample_0 .. sample_7 (lowest bit up), zero padded.
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // out_channel, is_connected, changed, clamped, average, board_led_mask
    // (lowest bit up), zero padded.
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    channel_continuity_hysteresis DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Local copy of the settings and of the channel and board state.
    cfg_t              model_cfg;
    logic              link_up    [TOTAL_CHANNELS];
    logic [MASK_W-1:0] board_leds [NUM_BOARDS];

    in_item_t  measurements_to_send [$];
    out_item_t link_reports_due     [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int result_count   = 0;
    int hot_ch [4];

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", result_count, what);
        mismatch_count++;
    endtask

    function automatic bit predict_link_update(input in_item_t meas, output out_item_t rep);
        int               sum;
        int               brd;
        int               loc;
        logic [THR_W-1:0] avg;
        logic             prev;
        logic             now;
        logic             clamp;
        logic [POS_W-1:0] pos;
        rep = '0;
        if (!model_cfg.enable || int'(meas.channel) >= TOTAL_CHANNELS) begin
            return 1'b0;
        end
        brd = int'(meas.channel) / CHANNELS_PER_BOARD;
        loc = int'(meas.channel) % CHANNELS_PER_BOARD;
        sum = 0;
        for (int k = 0; k < NUM_SAMPLES; k++) begin
            sum += int'(meas.samples[k]) & ((1 << SAMPLE_BITS) - 1);
        end
        avg   = THR_W'(sum / NUM_SAMPLES);
        prev  = link_up[meas.channel];
        clamp = (avg >= model_cfg.clamp_thr);
        if (clamp) begin
            now = 1'b0;
        end else if (avg > model_cfg.on_thr) begin
            now = 1'b1;
        end else if (avg < model_cfg.off_thr) begin
            now = 1'b0;
        end else begin
            now = prev;
        end
        if (now != prev) begin
            link_up[meas.channel] = now;
            pos = model_cfg.led_map[brd % NUM_MAPS][POS_W*loc +: POS_W];
            board_leds[brd][pos] = now;
        end
        rep.out_channel    = meas.channel;
        rep.is_connected   = now;
        rep.changed        = (now != prev);
        rep.clamped        = clamp;
        rep.average        = avg;
        rep.board_led_mask = board_leds[brd];
        return 1'b1;
    endfunction

    // Driver: a new transaction is offered only once the previous one has gone.
    always @(posedge aclk) begin : drive_measurements
        logic [S_TDATA_W-1:0] word;
        out_item_t            rep;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (predict_link_update(in_item_t'(s_tdata[IN_W-1:0]), rep)) begin
                    link_reports_due.push_back(rep);
                end
            end
            if (!s_tvalid || s_tready) begin
                if (measurements_to_send.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    word           = '0;
                    word[IN_W-1:0] = measurements_to_send.pop_front();
                    s_tdata  <= word;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_reports
        out_item_t got;
        out_item_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = out_item_t'(m_tdata[OUT_W-1:0]);
                if (link_reports_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, tdata %h", m_tdata));
                end else begin
                    want = link_reports_due.pop_front();
                    if (got.out_channel !== want.out_channel)
                        report_mismatch($sformatf("out_channel got %0d expected %0d",
                                                  got.out_channel, want.out_channel));
                    if (got.is_connected !== want.is_connected)
                        report_mismatch($sformatf("is_connected got %b expected %b",
                                                  got.is_connected, want.is_connected));
                    if (got.changed !== want.changed)
                        report_mismatch($sformatf("changed got %b expected %b",
                                                  got.changed, want.changed));
                    if (got.clamped !== want.clamped)
                        report_mismatch($sformatf("clamped got %b expected %b",
                                                  got.clamped, want.clamped));
                    if (got.average !== want.average)
                        report_mismatch($sformatf("average got %0d expected %0d",
                                                  got.average, want.average));
                    if (got.board_led_mask !== want.board_led_mask)
                        report_mismatch($sformatf("board_led_mask got %h expected %h",
                                                  got.board_led_mask, want.board_led_mask));
                    if (m_tdata[M_TDATA_W-1:OUT_W] !== '0)
                        report_mismatch($sformatf("padding got %h", m_tdata));
                end
                result_count++;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ENABLE:    model_cfg.enable    = value[0];
            CFG_ON_THR:    model_cfg.on_thr    = value[THR_W-1:0];
            CFG_OFF_THR:   model_cfg.off_thr   = value[THR_W-1:0];
            CFG_CLAMP_THR: model_cfg.clamp_thr = value[THR_W-1:0];
            CFG_LED_MAP0, CFG_LED_MAP1, CFG_LED_MAP2, CFG_LED_MAP3: begin
                model_cfg.led_map[MAP_SEL_W'(idx - CFG_LED_MAP0)] = value[MAP_W-1:0];
            end
            default: ;
        endcase
    endtask

    task automatic set_thresholds(input int on_v, input int off_v, input int clamp_v);
        write_reg(CFG_ON_THR, on_v);
        write_reg(CFG_OFF_THR, off_v);
        write_reg(CFG_CLAMP_THR, clamp_v);
    endtask

    // Checked at the falling edge so that every transfer of the cycle has settled.
    // The extra cycles cover items still in the pipeline that give no result.
    task automatic wait_until_drained();
        do @(negedge aclk);
        while (measurements_to_send.size() != 0 || s_tvalid || link_reports_due.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    function automatic in_item_t flat_measurement(input int ch, input int level);
        in_item_t meas;
        meas.channel = CH_W'(ch);
        for (int k = 0; k < NUM_SAMPLES; k++) begin
            meas.samples[k] = sample_t'(level);
        end
        return meas;
    endfunction

    function automatic int clip_sample(input int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    // Half the measurements cluster around the thresholds, so that the hysteresis
    // band and clamp edge are crossed often; the rest lies at the rails or anywhere.
    function automatic in_item_t random_measurement();
        in_item_t meas;
        int       kind;
        int       centre;
        int       spread;
        kind   = $urandom_range(9);
        spread = 0;
        meas.channel = ($urandom_range(1) == 1) ? CH_W'(hot_ch[$urandom_range(3)])
                                                 : CH_W'($urandom_range(31));
        case (kind)
            0, 1: centre = -1;
            2, 3: begin centre = int'(model_cfg.on_thr);    spread = 3; end
            4, 5: begin centre = int'(model_cfg.off_thr);   spread = 3; end
            6:    begin centre = int'(model_cfg.clamp_thr); spread = 2; end
            7:    begin centre = ($urandom_range(1) == 1) ? 4095 : 0; spread = 1; end
            default: begin centre = int'($urandom_range(4095)); spread = 40; end
        endcase
        for (int k = 0; k < NUM_SAMPLES; k++) begin
            if (centre < 0) begin
                meas.samples[k] = sample_t'($urandom_range(4095));
            end else begin
                meas.samples[k] = sample_t'(clip_sample(centre + int'($urandom_range(2 * spread))
                                                        - spread));
            end
        end
        return meas;
    endfunction

    task automatic random_config();
        int on_v;
        int off_v;
        int clamp_v;
        on_v  = $urandom_range(4095);
        off_v = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(on_v);
        case ($urandom_range(5))
            0:       clamp_v = 0;
            1:       clamp_v = 4095;
            default: clamp_v = $urandom_range(4095, on_v);
        endcase
        set_thresholds(on_v, off_v, clamp_v);
        for (int b = 0; b < NUM_MAPS; b++) begin
            write_reg(CFG_ADDR_W'(CFG_LED_MAP0 + b),
                      ($urandom_range(3) == 0) ? LED_MAP_RESET : $urandom_range(24'hFFFFFF));
        end
    endtask

    task automatic run_random_chunk(input int count, input int idle, input int stall,
                                    input bit pause_midway);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < 4; i++) begin
            hot_ch[i] = $urandom_range(31);
        end
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) begin
                wait_until_drained();
            end
            measurements_to_send.push_back(random_measurement());
        end
        wait_until_drained();
    endtask

    initial begin : sequence_phases
        in_item_t meas;
        int       idle_by_phase  [4] = '{0, 88, 0, 32};
        int       stall_by_phase [4] = '{0, 0, 88, 32};

        model_cfg.enable    = 1'b1;
        model_cfg.on_thr    = ON_THR_RESET;
        model_cfg.off_thr   = OFF_THR_RESET;
        model_cfg.clamp_thr = CLAMP_THR_RESET;
        for (int b = 0; b < NUM_MAPS; b++) model_cfg.led_map[b] = LED_MAP_RESET;
        for (int c = 0; c < TOTAL_CHANNELS; c++) link_up[c] = 1'b0;
        for (int b = 0; b < NUM_BOARDS; b++) board_leds[b] = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: hysteresis edges on both thresholds, then the clamp.
        measurements_to_send.push_back(flat_measurement(0, 0));
        measurements_to_send.push_back(flat_measurement(0, 2049));
        measurements_to_send.push_back(flat_measurement(0, 2048));
        measurements_to_send.push_back(flat_measurement(0, 1024));
        measurements_to_send.push_back(flat_measurement(0, 1023));
        measurements_to_send.push_back(flat_measurement(31, 4095));
        measurements_to_send.push_back(flat_measurement(31, 3000));
        measurements_to_send.push_back(flat_measurement(31, 4095));
        // Truncation of the mean near zero, the clamp and the on threshold.
        meas = flat_measurement(5, 0);
        meas.samples[3] = 12'd7;
        measurements_to_send.push_back(meas);
        meas = flat_measurement(5, 4095);
        meas.samples[7] = 12'd4088;
        measurements_to_send.push_back(meas);
        meas = flat_measurement(5, 2049);
        meas.samples[0] = 12'd2056;
        measurements_to_send.push_back(meas);
        measurements_to_send.push_back(flat_measurement(10, 12'hAAA));
        measurements_to_send.push_back(flat_measurement(21, 12'h555));
        measurements_to_send.push_back(flat_measurement(8, 3000));
        measurements_to_send.push_back(flat_measurement(11, 3000));
        measurements_to_send.push_back(flat_measurement(13, 3000));
        measurements_to_send.push_back(flat_measurement(15, 3000));
        wait_until_drained();

        // Disabled sensing must leave channel 8 connected.
        write_reg(CFG_ENABLE, 0);
        measurements_to_send.push_back(flat_measurement(8, 0));
        measurements_to_send.push_back(flat_measurement(8, 4095));
        wait_until_drained();
        write_reg(CFG_ENABLE, 1);
        measurements_to_send.push_back(flat_measurement(8, 2048));
        wait_until_drained();

        // Crossed thresholds, with maps that fold boards 0 and 1 onto one bit and board 2 onto two.
        set_thresholds(100, 3000, 4095);
        write_reg(CFG_LED_MAP0, 0);
        write_reg(CFG_LED_MAP1, 24'hFFFFFF);
        write_reg(CFG_LED_MAP2, 24'h000FFF);
        write_reg(CFG_LED_MAP3, LED_MAP_RESET);
        measurements_to_send.push_back(flat_measurement(1, 2000));
        measurements_to_send.push_back(flat_measurement(2, 50));
        measurements_to_send.push_back(flat_measurement(9, 2000));
        measurements_to_send.push_back(flat_measurement(20, 101));
        wait_until_drained();

        // A zero clamp threshold clamps everything.
        set_thresholds(0, 4095, 0);
        measurements_to_send.push_back(flat_measurement(1, 0));
        measurements_to_send.push_back(flat_measurement(9, 4095));
        wait_until_drained();

        set_thresholds(4095, 0, 4095);
        measurements_to_send.push_back(flat_measurement(20, 4094));
        measurements_to_send.push_back(flat_measurement(20, 4095));
        measurements_to_send.push_back(flat_measurement(20, 0));
        wait_until_drained();

        for (int c = 0; c < 8; c++) begin
            if (c == 5) begin
                write_reg(CFG_ENABLE, 0);
                send_idle_pct = 32;
                for (int i = 0; i < 16; i++) begin
                    measurements_to_send.push_back(random_measurement());
                end
                wait_until_drained();
                write_reg(CFG_ENABLE, 1);
            end
            random_config();
            run_random_chunk(225, idle_by_phase[c % 4], stall_by_phase[c % 4], c == 2);
        end

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
